@@ src/pld_pkg.sv @@
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types, constants and detector tables for the listmode word decoder.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int WORD_W        = 64;
  localparam int COORD_W       = 8;
  localparam int TIME_W        = 29;
  localparam int NUM_W         = 32;
  localparam int INDEX_W       = 16;
  localparam int STATUS_W      = 2;
  localparam int CODE_W        = 6;
  localparam int UNIT_W        = 4;
  localparam int PAIR_CODES    = 42;
  localparam int COORD_LIMIT   = 52;
  localparam int SPLIT         = 13;
  localparam int CRYSTALS      = 169;
  localparam int SECTOR_OFFSET = 10;
  localparam int TDATA_W       = 96;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PAIR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_COORD = 2'd2;

  localparam logic [2:0] TAG_TIME = 3'b100;

  localparam logic [UNIT_W-1:0] UNIT_FIRST [PAIR_CODES] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8
  };

  localparam logic [UNIT_W-1:0] UNIT_SECOND [PAIR_CODES] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
    4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
    4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd8, 4'd9, 4'd10, 4'd11, 4'd9, 4'd10, 4'd11, 4'd10,
    4'd11, 4'd11
  };

  typedef struct packed {
    logic [1:0] q;
    logic [3:0] r;
  } pld_split_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [UNIT_W-1:0]   unit_a;
    logic [UNIT_W-1:0]   unit_b;
    pld_split_t          ax;
    pld_split_t          ay;
    pld_split_t          bx;
    pld_split_t          by;
    logic [TIME_W-1:0]   event_time;
    logic [NUM_W-1:0]    event_number;
    logic                prompt_flag;
  } pld_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pld_qstat_t;

  // Split a coordinate below 52 into quotient and remainder by 13.
  function automatic pld_split_t split13(input logic [COORD_W-1:0] v);
    pld_split_t   s;
    logic [COORD_W-1:0] rem;
    if (v >= COORD_W'(3 * SPLIT)) begin
      s.q = 2'd3;
    end else if (v >= COORD_W'(2 * SPLIT)) begin
      s.q = 2'd2;
    end else if (v >= COORD_W'(SPLIT)) begin
      s.q = 2'd1;
    end else begin
      s.q = 2'd0;
    end
    rem = v - COORD_W'(s.q) * COORD_W'(SPLIT);
    s.r = rem[3:0];
    return s;
  endfunction

endpackage

@@ src/pld_front.sv @@
// ----------------------------------------------------------------------------
// pld_front
// Accepts listmode words, applies time tags, counts events and classifies
// each event word into a queue entry.
// ----------------------------------------------------------------------------
module pld_front import pld_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [WORD_W-1:0]   word,
  input  pld_qstat_t          qstat,
  output logic                in_ready,
  output logic                push,
  output pld_entry_t          entry
);

  logic [TIME_W-1:0]  time_marker;
  logic [NUM_W-1:0]   event_counter;
  logic               accept;
  logic               is_tag;
  logic               is_time_tag;
  logic [CODE_W-1:0]  code;
  logic [CODE_W-1:0]  code_idx;
  logic               code_ok;
  logic               coord_ok;
  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] ay;
  logic [COORD_W-1:0] bx;
  logic [COORD_W-1:0] by;

  assign in_ready    = !qstat.full;
  assign accept      = in_valid && in_ready;
  assign is_tag      = word[30];
  assign is_time_tag = is_tag && (word[47:45] == TAG_TIME);
  assign push        = accept && !is_tag;

  assign code     = {word[50:48], word[18:16]};
  assign code_ok  = (code >= CODE_W'(1)) && (code <= CODE_W'(PAIR_CODES));
  assign code_idx = code_ok ? (code - CODE_W'(1)) : '0;
  assign ax       = word[7:0];
  assign ay       = word[15:8];
  assign bx       = word[39:32];
  assign by       = word[47:40];
  assign coord_ok = (ax < COORD_W'(COORD_LIMIT)) && (ay < COORD_W'(COORD_LIMIT)) &&
                    (bx < COORD_W'(COORD_LIMIT)) && (by < COORD_W'(COORD_LIMIT));

  always_comb begin
    if (!code_ok) begin
      entry.status = ST_BAD_PAIR;
    end else if (!coord_ok) begin
      entry.status = ST_BAD_COORD;
    end else begin
      entry.status = ST_OK;
    end
    entry.unit_a       = UNIT_FIRST[code_idx];
    entry.unit_b       = UNIT_SECOND[code_idx];
    entry.ax           = split13(ax);
    entry.ay           = split13(ay);
    entry.bx           = split13(bx);
    entry.by           = split13(by);
    entry.event_time   = time_marker;
    entry.event_number = event_counter;
    entry.prompt_flag  = word[62];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_marker   <= '0;
      event_counter <= '0;
    end else if (accept) begin
      if (is_time_tag) begin
        time_marker <= {word[44:40], word[39:32], word[15:8], word[7:0]};
      end
      if (!is_tag && (event_counter != '1)) begin
        event_counter <= event_counter + NUM_W'(1);
      end
    end
  end

endmodule

@@ src/pld_queue.sv @@
// ----------------------------------------------------------------------------
// pld_queue
// Small first-in first-out queue of classified events between front and back.
// ----------------------------------------------------------------------------
module pld_queue import pld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pld_entry_t push_entry,
  input  logic       pop,
  output pld_entry_t pop_entry,
  output pld_qstat_t qstat
);

  pld_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/pld_back.sv @@
// ----------------------------------------------------------------------------
// pld_back
// Packs queued events into global crystal indices and holds the result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module pld_back import pld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  pld_qstat_t           qstat,
  input  pld_entry_t           entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TDATA_W-1:0]   out_data,
  output logic                 out_user
);

  logic [INDEX_W-1:0]  index_a;
  logic [INDEX_W-1:0]  index_b;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  index_a_r;
  logic [INDEX_W-1:0]  index_b_r;
  logic [TIME_W-1:0]   time_r;
  logic [NUM_W-1:0]    number_r;
  logic                prompt_r;

  function automatic logic [INDEX_W-1:0] pack_index(
    input logic [UNIT_W-1:0] unit,
    input pld_split_t        cx,
    input pld_split_t        cy
  );
    logic [5:0] sector;
    logic [1:0] module_sel;
    logic [7:0] row;
    logic [7:0] crystal;
    sector     = 6'({unit, 2'b00}) + 6'(cx.q) + 6'(SECTOR_OFFSET);
    module_sel = 2'd3 - cy.q;
    row        = 8'(module_sel) + {sector, 2'b00};
    crystal    = 8'(4'd12 - cy.r) * 8'(SPLIT) + 8'(cx.r);
    return INDEX_W'(row) * INDEX_W'(CRYSTALS) + INDEX_W'(crystal);
  endfunction

  assign pop     = !qstat.empty && (!out_valid || out_ready);
  assign index_a = pack_index(entry.unit_a, entry.ax, entry.ay);
  assign index_b = pack_index(entry.unit_b, entry.bx, entry.by);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status    <= entry.status;
      index_a_r <= (entry.status == ST_OK) ? index_a : '0;
      index_b_r <= (entry.status == ST_OK) ? index_b : '0;
      time_r    <= entry.event_time;
      number_r  <= entry.event_number;
      prompt_r  <= entry.prompt_flag;
    end
  end

  assign out_data = {1'b0, number_r, time_r, index_b_r, index_a_r, status};
  assign out_user = prompt_r;

endmodule

@@ src/pet_listmode_word_decoder.sv @@
// ----------------------------------------------------------------------------
// pet_listmode_word_decoder
// Decodes 64-bit listmode words: time tags load the time register, event
// words become crystal index pairs with time, event number and prompt flag.
// Path: an event is queued, then loaded into the output register behind m_tvalid.
// Throughput: one word per cycle unless the four-entry event queue is full.
// The queue decouples input; tags give no result.
// Reset: clears time register, event counter, queue and output valid.
// ----------------------------------------------------------------------------
module pet_listmode_word_decoder import pld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [WORD_W-1:0]    s_tdata,   // listmode_word[63:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // decode_status[1:0], xtal_idx_a[17:2],
                                          // xtal_idx_b[33:18], event_time[62:34],
                                          // event_number[94:63], zero pad[95]
  output logic                 m_tuser    // prompt_flag[0]
);

  pld_qstat_t qstat;
  pld_entry_t push_entry;
  pld_entry_t pop_entry;
  logic       push;
  logic       pop;

  pld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .word     (s_tdata),
    .qstat    (qstat),
    .in_ready (s_tready),
    .push     (push),
    .entry    (push_entry)
  );

  pld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  pld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .entry     (pop_entry),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue pushed while full");

  a_bad_zero_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == '0))
    else $error("flagged event carries nonzero crystal index");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("undefined decode status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule
